### src/assert_macros.svh
// Assertion macros shared by the packer RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define LCDP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a rising clock edge outside reset.
`define LCDP_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### src/lcdp_pkg.sv
// Shared types, codes and constants of the character-LCD command packer.
`default_nettype none
package lcdp_pkg;

	// Operation codes of an input item.
	typedef enum logic [2:0] {
		OP_WRITE_CHAR   = 3'd0,
		OP_SET_POSITION = 3'd1,
		OP_CLEAR        = 3'd2,
		OP_HOME         = 3'd3,
		OP_GLYPH_SELECT = 3'd4,
		OP_GLYPH_ROW    = 3'd5,
		OP_FLUSH        = 3'd6
	} op_code_t;

	// Configuration register indexes.
	localparam logic [0:0] CFG_DISPLAY_ROWS    = 1'b0;
	localparam logic [0:0] CFG_DISPLAY_COLUMNS = 1'b1;

	localparam logic [2:0] ROWS_RESET    = 3'd2;
	localparam logic [5:0] COLUMNS_RESET = 6'd16;

	// Request type and controller target codes, already in their byte positions.
	localparam logic [7:0] T_CMD    = 8'h20;
	localparam logic [7:0] T_DATA   = 8'h40;
	localparam logic [7:0] TGT_0    = 8'h08;
	localparam logic [7:0] TGT_1    = 8'h10;
	localparam logic [7:0] TGT_BOTH = 8'h18;

	// HD44780 command bytes.
	localparam logic [7:0] CMD_CLEAR = 8'h01;
	localparam logic [7:0] CMD_HOME  = 8'h03;
	localparam logic [7:0] CMD_DDRAM = 8'h80;
	localparam logic [7:0] CMD_CGRAM = 8'h40;
	localparam logic [7:0] GLYPH_ROW_MASK = 8'h1f;

	// Bytes collected per request before it is sent.
	localparam int BUFFER_BYTES = 4;

	// Depth of the queue between front and back.
	localparam int FIFO_DEPTH = 2;

	// Work for the back end: up to two bytes of one type, then an optional flush.
	typedef struct packed {
		logic [1:0] nbytes;
		logic [7:0] req_type;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       flush;
	} entry_t;

	// Map the host's custom-glyph character codes to CGRAM slots.
	function automatic logic [7:0] map_char(input logic [7:0] c);
		logic [7:0] m;
		case (c)
			8'd176: m = 8'd0;
			8'd158: m = 8'd1;
			8'd131: m = 8'd2;
			8'd132: m = 8'd3;
			8'd133: m = 8'd4;
			8'd134: m = 8'd5;
			8'd135: m = 8'd6;
			8'd136: m = 8'd7;
			default: m = c;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

### src/lcdp_op_if.sv
// Operation request channel of the packer.
`default_nettype none
interface lcdp_op_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [7:0] byte_value;
	logic [5:0] col_x;
	logic [1:0] row_y;
	logic       flush_after;

	modport source (output valid, operation, byte_value, col_x, row_y, flush_after,
		input ready);
	modport sink (input valid, operation, byte_value, col_x, row_y, flush_after,
		output ready);
endinterface
`default_nettype wire

### src/lcdp_req_if.sv
// Packed link request channel of the packer.
`default_nettype none
interface lcdp_req_if;
	logic        valid;
	logic        ready;
	logic [7:0]  request_byte;
	logic [15:0] value_word;
	logic [15:0] index_word;
	logic        last;

	modport source (output valid, request_byte, value_word, index_word, last,
		input ready);
	modport sink (input valid, request_byte, value_word, index_word, last,
		output ready);
endinterface
`default_nettype wire

### src/lcdp_cfg_if.sv
// Configuration write channel of the packer.
`default_nettype none
interface lcdp_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [5:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/lcdp_front.sv
// Front end: holds configuration and cursor, turns each operation into queue work.
`default_nettype none
module lcdp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	lcdp_op_if.sink            op,
	lcdp_cfg_if.sink           cfg,
	output lcdp_pkg::entry_t   entry,
	output logic               push_valid,
	input  wire logic          push_ready
);

	logic [2:0] rows_q;
	logic [5:0] cols_q;
	logic [5:0] cursor_x_q;
	logic       second_q;

	logic [5:0] cursor_x_d;
	logic       second_d;
	logic [7:0] tgt_cur;
	logic       pos_second;
	logic [1:0] pos_y;
	logic [7:0] pos_addr;
	logic       narrow16;
	logic       accept;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= lcdp_pkg::ROWS_RESET;
			cols_q <= lcdp_pkg::COLUMNS_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				lcdp_pkg::CFG_DISPLAY_ROWS:    rows_q <= cfg.data[2:0];
				lcdp_pkg::CFG_DISPLAY_COLUMNS: cols_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Accept an operation whenever the queue has room.
	assign op.ready   = push_ready;
	assign push_valid = op.valid;
	assign accept     = op.valid && push_ready;

	// DDRAM address: large displays put rows two and three on the second controller.
	assign tgt_cur    = second_q ? lcdp_pkg::TGT_1 : lcdp_pkg::TGT_0;
	assign pos_second = (rows_q > 3'd2) && (cols_q > 6'd20) && op.row_y[1];
	assign pos_y      = pos_second ? {1'b0, op.row_y[0]} : op.row_y;
	assign narrow16   = (rows_q == 3'd4) && (cols_q == 6'd16);
	assign pos_addr   = {1'b0, pos_y[0], 6'b0}
		+ (pos_y[1] ? (narrow16 ? 8'd16 : 8'd20) : 8'd0)
		+ {2'b00, op.col_x};

	// Classify the operation into bytes of one type and update the cursor.
	always_comb begin
		entry      = '0;
		cursor_x_d = cursor_x_q;
		second_d   = second_q;
		unique case (op.operation)
			lcdp_pkg::OP_WRITE_CHAR: begin
				if (cursor_x_q < cols_q) begin
					cursor_x_d     = cursor_x_q + 6'd1;
					entry.nbytes   = 2'd1;
					entry.req_type = lcdp_pkg::T_DATA | tgt_cur;
					entry.byte0    = lcdp_pkg::map_char(op.byte_value);
				end
			end
			lcdp_pkg::OP_SET_POSITION: begin
				cursor_x_d     = op.col_x;
				second_d       = pos_second;
				entry.nbytes   = 2'd1;
				entry.req_type = lcdp_pkg::T_CMD
					| (pos_second ? lcdp_pkg::TGT_1 : lcdp_pkg::TGT_0);
				entry.byte0    = lcdp_pkg::CMD_DDRAM | pos_addr;
			end
			lcdp_pkg::OP_CLEAR: begin
				cursor_x_d     = '0;
				second_d       = 1'b0;
				entry.nbytes   = 2'd2;
				entry.req_type = lcdp_pkg::T_CMD | lcdp_pkg::TGT_BOTH;
				entry.byte0    = lcdp_pkg::CMD_CLEAR;
				entry.byte1    = lcdp_pkg::CMD_HOME;
			end
			lcdp_pkg::OP_HOME: begin
				cursor_x_d     = '0;
				second_d       = 1'b0;
				entry.nbytes   = 2'd1;
				entry.req_type = lcdp_pkg::T_CMD | lcdp_pkg::TGT_BOTH;
				entry.byte0    = lcdp_pkg::CMD_HOME;
			end
			lcdp_pkg::OP_GLYPH_SELECT: begin
				entry.nbytes   = 2'd1;
				entry.req_type = lcdp_pkg::T_CMD | lcdp_pkg::TGT_BOTH;
				entry.byte0    = lcdp_pkg::CMD_CGRAM | {op.byte_value[4:0], 3'b000};
			end
			lcdp_pkg::OP_GLYPH_ROW: begin
				entry.nbytes   = 2'd1;
				entry.req_type = lcdp_pkg::T_DATA | lcdp_pkg::TGT_BOTH;
				entry.byte0    = op.byte_value & lcdp_pkg::GLYPH_ROW_MASK;
			end
			lcdp_pkg::OP_FLUSH: begin
				entry.flush = 1'b1;
			end
			default: ;
		endcase
		if (op.flush_after) begin
			entry.flush = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			second_q   <= 1'b0;
		end else if (accept) begin
			cursor_x_q <= cursor_x_d;
			second_q   <= second_d;
		end
	end

endmodule
`default_nettype wire

### src/lcdp_fifo.sv
// Short queue of work entries between the front and the back end.
`default_nettype none
`include "assert_macros.svh"
module lcdp_fifo #(
	parameter int DEPTH = lcdp_pkg::FIFO_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lcdp_pkg::entry_t  push_entry,
	input  wire logic              push_valid,
	output logic                   push_ready,
	output lcdp_pkg::entry_t       pop_entry,
	output logic                   pop_valid,
	input  wire logic              pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lcdp_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers wrap at the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	`LCDP_ASSERT(a_fifo_count_bound, clk, arst_n, (count_q <= CNT_W'(DEPTH)), "queue count beyond depth")

endmodule
`default_nettype wire

### src/lcdp_back.sv
// Back end: collects bytes into the request buffer and sends packed requests.
`default_nettype none
`include "assert_macros.svh"
module lcdp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lcdp_pkg::entry_t  pop_entry,
	input  wire logic              pop_valid,
	output logic                   pop_ready,
	lcdp_req_if.source             req
);

	localparam logic [2:0] FULL_COUNT = 3'(lcdp_pkg::BUFFER_BYTES);

	typedef struct packed {
		logic [7:0]  request_byte;
		logic [15:0] value_word;
		logic [15:0] index_word;
		logic        last;
	} res_t;

	typedef struct packed {
		logic            pv;
		logic [7:0]      pt;
		logic [2:0]      fc;
		logic [3:0][7:0] bufb;
		logic [1:0]      rn;
		res_t [1:0]      r;
	} work_t;

	// Send the pending buffer as a request, at most two per entry.
	function automatic work_t do_emit(input work_t w);
		work_t      n;
		logic [2:0] cm1;
		n   = w;
		cm1 = w.fc - 3'd1;
		if (w.pv && (w.fc != 3'd0) && (w.rn < 2'd2)) begin
			n.r[w.rn[0]].request_byte = w.pt | {6'b0, cm1[1:0]};
			n.r[w.rn[0]].value_word   = {w.bufb[1], w.bufb[0]};
			n.r[w.rn[0]].index_word   = {w.bufb[3], w.bufb[2]};
			n.r[w.rn[0]].last         = 1'b0;
			n.rn = w.rn + 2'd1;
			n.pv = 1'b0;
			n.fc = 3'd0;
		end
		return n;
	endfunction

	// Add one byte; a type change or a full buffer sends what is pending first.
	function automatic work_t do_enq(input work_t w, input logic [7:0] t, input logic [7:0] v);
		work_t n;
		n = w;
		if (n.pv && ((n.pt != t) || (n.fc >= FULL_COUNT))) begin
			n = do_emit(n);
		end
		if (!(n.pv && ((n.pt != t) || (n.fc >= FULL_COUNT)))) begin
			n.pv = 1'b1;
			n.pt = t;
			n.bufb[n.fc[1:0]] = v;
			n.fc = n.fc + 3'd1;
			if (n.fc >= FULL_COUNT) begin
				n = do_emit(n);
			end
		end
		return n;
	endfunction

	logic            pv_q;
	logic [7:0]      pt_q;
	logic [2:0]      fc_q;
	logic [3:0][7:0] buf_q;
	logic            out_valid_q;
	res_t            out_res_q;
	logic            hold_valid_q;
	res_t            hold_res_q;

	work_t w_in;
	work_t w_out;
	logic  slot_free;
	logic  do_pop;

	// Run one entry through the buffer.
	always_comb begin
		w_in      = '0;
		w_in.pv   = pv_q;
		w_in.pt   = pt_q;
		w_in.fc   = fc_q;
		w_in.bufb = buf_q;
		w_out     = w_in;
		if (pop_entry.nbytes != 2'd0) begin
			w_out = do_enq(w_out, pop_entry.req_type, pop_entry.byte0);
		end
		if (pop_entry.nbytes == 2'd2) begin
			w_out = do_enq(w_out, pop_entry.req_type, pop_entry.byte1);
		end
		if (pop_entry.flush) begin
			w_out = do_emit(w_out);
		end
		// The last request of the entry carries the last flag.
		w_out.r[0].last = (w_out.rn == 2'd1);
		w_out.r[1].last = 1'b1;
	end

	// A second request waits in the hold register; no new entry until it has moved on.
	assign slot_free = !out_valid_q || req.ready;
	assign pop_ready = !hold_valid_q && slot_free;
	assign do_pop    = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q         <= 1'b0;
			pt_q         <= '0;
			fc_q         <= '0;
			buf_q        <= '0;
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (hold_valid_q && slot_free) begin
			out_valid_q  <= 1'b1;
			hold_valid_q <= 1'b0;
		end else if (do_pop) begin
			pv_q  <= w_out.pv;
			pt_q  <= w_out.pt;
			fc_q  <= w_out.fc;
			buf_q <= w_out.bufb;
			out_valid_q  <= (w_out.rn != 2'd0);
			hold_valid_q <= (w_out.rn == 2'd2);
		end else if (out_valid_q && req.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Request payload registers.
	always_ff @(posedge clk) begin
		if (hold_valid_q && slot_free) begin
			out_res_q <= hold_res_q;
		end else if (do_pop) begin
			out_res_q  <= w_out.r[0];
			hold_res_q <= w_out.r[1];
		end
	end

	assign req.valid        = out_valid_q;
	assign req.request_byte = out_res_q.request_byte;
	assign req.value_word   = out_res_q.value_word;
	assign req.index_word   = out_res_q.index_word;
	assign req.last         = out_res_q.last;

	`LCDP_ASSERT(a_hold_behind_out, clk, arst_n, (hold_valid_q |-> out_valid_q), "second request held without a first")
	`LCDP_ASSERT(a_pending_matches_count, clk, arst_n, (pv_q == (fc_q != 3'd0)), "pending flag and fill count disagree")
	`LCDP_NEVER(a_buffer_never_full, clk, arst_n, (fc_q >= FULL_COUNT), "full buffer left pending")

endmodule
`default_nettype wire

### src/char_lcd_command_packer_unit.sv
// Top level of the character-LCD command packer.
//
// Channels: op takes one LCD operation per request (write char, set position,
// clear, home, glyph select, glyph row, flush), req gives packed link requests
// of type, target and byte count with up to four bytes, and cfg writes the
// display rows (index 0) and columns (index 1); cfg is always ready.
// A request that an operation causes is registered in the queue and then in the
// output register before it is valid. Throughput: one operation per cycle while
// each causes at most one request and req takes every request; an operation that
// causes two requests holds the back end while the second waits in the hold
// register, since requests leave through a single output register.
// A two-entry queue separates the front end from the back end, so the front
// keeps taking operations while the back waits on a stalled receiver; once
// the queue is full, op.ready drops until req is taken again.
// Reset clears the request buffer, the cursor and the queue, and sets the
// display to two rows of sixteen columns. Bytes of a request past its count
// show the stale buffer contents.
`default_nettype none
module char_lcd_command_packer_unit #(
	parameter int FIFO_DEPTH = lcdp_pkg::FIFO_DEPTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lcdp_op_if.sink     op,
	lcdp_req_if.source  req,
	lcdp_cfg_if.sink    cfg
);

	lcdp_pkg::entry_t push_entry;
	lcdp_pkg::entry_t pop_entry;
	logic             push_valid;
	logic             push_ready;
	logic             pop_valid;
	logic             pop_ready;

	// Classify operations and track the cursor.
	lcdp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.cfg        (cfg),
		.entry      (push_entry),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// Queue between the two halves.
	lcdp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_entry (push_entry),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_entry  (pop_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// Pack bytes into requests.
	lcdp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_entry (pop_entry),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.req       (req)
	);

endmodule
`default_nettype wire
